@@ src/vcu_pkg.sv @@
// Shared constants, command and relation codes and types of the vector clock unit.
package vcu_pkg;

    localparam int NODES_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam int CMD_W = 2;
    localparam int ID_W  = 4;
    localparam int CNT_W = 32;
    localparam int REL_W = 2;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MERGE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPARE = 2'd2;

    localparam logic [REL_W-1:0] REL_EQUAL      = 2'd0;
    localparam logic [REL_W-1:0] REL_BEFORE     = 2'd1;
    localparam logic [REL_W-1:0] REL_AFTER      = 2'd2;
    localparam logic [REL_W-1:0] REL_CONCURRENT = 2'd3;

    // status of the shared compare/increment unit
    typedef struct packed {
        logic lt;
        logic gt;
        logic at_max;
    } alu_flags_t;

endpackage

@@ src/vcu_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface vcu_item_if import vcu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  node_id;
    logic [CNT_W-1:0] entry_count;
    logic             last_entry;

    modport source (output valid, cmd, node_id, entry_count, last_entry, input ready);
    modport sink   (input valid, cmd, node_id, entry_count, last_entry, output ready);
endinterface

interface vcu_result_if import vcu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] entry_value;
    logic             overflow;
    logic             relation_valid;
    logic [REL_W-1:0] relation;

    modport source (output valid, entry_value, overflow, relation_valid, relation, input ready);
    modport sink   (input valid, entry_value, overflow, relation_valid, relation, output ready);
endinterface

@@ src/vcu_alu.sv @@
// Shared counter unit: magnitude compare, saturation test and increment.
module vcu_alu import vcu_pkg::*; #(
    parameter int W = TIME_BITS_DEF
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] inc,
    output alu_flags_t   flags
);

    assign inc          = a + W'(1);
    assign flags.lt     = (a < b);
    assign flags.gt     = (a > b);
    assign flags.at_max = (a == {W{1'b1}});

endmodule

@@ src/vcu_clock_mem.sv @@
// Counter memory with per-entry valid bits; an unwritten entry reads as zero.
module vcu_clock_mem import vcu_pkg::*; #(
    parameter  int NODES = NODES_DEF,
    parameter  int W     = TIME_BITS_DEF,
    localparam int AW    = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0]     clock_mem [NODES];
    logic [NODES-1:0] valid_reg;
    logic [W-1:0]     rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            clock_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= clock_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ src/vector_clock_unit_core.sv @@
// Vector clock unit top level: item sequencer, stream flags and result register.
// Tick, merge and non-final compare: accept, one memory read, an execute step, then the
// result register. A final compare adds a sweep over all NODES counters through the single
// read port. One item is in flight at a time; ready is high only while idle.
// Reset clears all counters (valid bits), the compare stream flags and the output valid flag.
module vector_clock_unit_core import vcu_pkg::*; #(
    parameter int NODES     = NODES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    vcu_item_if.sink     item,
    vcu_result_if.source result
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0]           state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIME_BITS-1:0] other_reg;
    logic                 last_reg;
    logic [NODES-1:0]     seen_reg, seen_next;
    logic                 any_less_reg, any_less_next;
    logic                 any_greater_reg, any_greater_next;
    logic [CW-1:0]        k_reg, k_next;
    logic                 pend_reg, pend_next;
    logic                 pend_seen_reg;
    logic [CNT_W-1:0]     res_value_reg, res_value_next;
    logic                 res_ovf_reg, res_ovf_next;
    logic                 res_rvalid_reg, res_rvalid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]     out_value_reg;
    logic                 out_ovf_reg;
    logic                 out_rvalid_reg;
    logic [REL_W-1:0]     out_rel_reg;

    logic                 accept;
    logic                 out_load;
    logic                 id_ok;
    logic [AW-1:0]        addr_id;
    logic [AW-1:0]        addr_k;
    logic                 take;
    logic [TIME_BITS-1:0] mine;
    logic [TIME_BITS-1:0] new_val;
    logic [REL_W-1:0]     rel;

    logic                 wr_en;
    logic [TIME_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [TIME_BITS-1:0] rd_data;

    logic [TIME_BITS-1:0] alu_a;
    logic [TIME_BITS-1:0] alu_b;
    logic [TIME_BITS-1:0] alu_inc;
    alu_flags_t           flags;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;

    assign id_ok   = (32'(id_reg) < 32'(NODES));
    assign addr_id = AW'(id_reg);
    assign addr_k  = k_reg[AW-1:0];
    assign mine    = id_ok ? rd_data : '0;

    // shared unit: execute compares against the other counter, sweep tests for nonzero
    assign alu_a = (state_reg == S_SWEEP) ? rd_data : mine;
    assign alu_b = (state_reg == S_SWEEP) ? '0 : other_reg;

    vcu_alu #(.W(TIME_BITS)) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .inc   (alu_inc),
        .flags (flags)
    );

    vcu_clock_mem #(.NODES(NODES), .W(TIME_BITS)) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (addr_id),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_en   = accept || ((state_reg == S_SWEEP) && (k_reg < CW'(NODES)));
    assign rd_addr = (state_reg == S_SWEEP) ? addr_k : AW'(item.node_id);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        if (!res_rvalid_reg)
        begin
            rel = REL_EQUAL;
        end
        else if (any_less_reg && any_greater_reg)
        begin
            rel = REL_CONCURRENT;
        end
        else if (any_less_reg)
        begin
            rel = REL_BEFORE;
        end
        else if (any_greater_reg)
        begin
            rel = REL_AFTER;
        end
        else
        begin
            rel = REL_EQUAL;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        seen_next        = seen_reg;
        any_less_next    = any_less_reg;
        any_greater_next = any_greater_reg;
        k_next           = k_reg;
        pend_next        = 1'b0;
        res_value_next   = res_value_reg;
        res_ovf_next     = res_ovf_reg;
        res_rvalid_next  = res_rvalid_reg;
        wr_en            = 1'b0;
        wr_data          = alu_inc;
        new_val          = mine;
        take             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_ovf_next    = 1'b0;
                res_rvalid_next = 1'b0;
                state_next      = S_DONE;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (id_ok)
                        begin
                            if (flags.at_max)
                            begin
                                res_ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_data = alu_inc;
                                new_val = alu_inc;
                            end
                        end
                    end
                    CMD_MERGE:
                    begin
                        if (id_ok && flags.lt)
                        begin
                            wr_en   = 1'b1;
                            wr_data = other_reg;
                            new_val = other_reg;
                        end
                    end
                    CMD_COMPARE:
                    begin
                        // a repeated id in the open stream keeps its first entry
                        take = !id_ok || !seen_reg[addr_id];
                        if (id_ok && take)
                        begin
                            seen_next[addr_id] = 1'b1;
                        end
                        if (take)
                        begin
                            if (flags.lt)
                            begin
                                any_less_next = 1'b1;
                            end
                            else if (flags.gt)
                            begin
                                any_greater_next = 1'b1;
                            end
                        end
                        if (last_reg)
                        begin
                            res_rvalid_next = 1'b1;
                            k_next          = '0;
                            state_next      = S_SWEEP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                res_value_next = id_ok ? CNT_W'(new_val) : '0;
            end
            S_SWEEP:
            begin
                // read of entry k is issued here, its check lands in the next cycle
                if (k_reg < CW'(NODES))
                begin
                    k_next    = k_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && !pend_seen_reg && flags.gt)
                begin
                    any_greater_next = 1'b1;
                end
                if (pend_reg && (k_reg == CW'(NODES)))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                    if (res_rvalid_reg)
                    begin
                        seen_next        = '0;
                        any_less_next    = 1'b0;
                        any_greater_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            seen_reg        <= '0;
            any_less_reg    <= 1'b0;
            any_greater_reg <= 1'b0;
            k_reg           <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            seen_reg        <= seen_next;
            any_less_reg    <= any_less_next;
            any_greater_reg <= any_greater_next;
            k_reg           <= k_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.cmd;
            id_reg    <= item.node_id;
            other_reg <= TIME_BITS'(item.entry_count);
            last_reg  <= item.last_entry;
        end
        if ((state_reg == S_SWEEP) && (k_reg < CW'(NODES)))
        begin
            pend_seen_reg <= seen_reg[addr_k];
        end
        res_value_reg  <= res_value_next;
        res_ovf_reg    <= res_ovf_next;
        res_rvalid_reg <= res_rvalid_next;
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_ovf_reg    <= res_ovf_reg;
            out_rvalid_reg <= res_rvalid_reg;
            out_rel_reg    <= rel;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.entry_value    = out_value_reg;
    assign result.overflow       = out_ovf_reg;
    assign result.relation_valid = out_rvalid_reg;
    assign result.relation       = out_rel_reg;

endmodule

@@ src/vcu_chk.sv @@
// Port-level assertions for the vector clock unit and their bind to the top level.
module vcu_chk import vcu_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CNT_W-1:0] entry_value,
    input logic             overflow,
    input logic             relation_valid,
    input logic [REL_W-1:0] relation
);

    // one item in flight: ready drops right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready high in the cycle after an accepted beat");

    a_rel_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !relation_valid) |-> (relation == REL_EQUAL))
        else $error("relation set on a result without relation_valid");

    a_ovf_not_with_rel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && relation_valid))
        else $error("overflow and relation_valid on the same result");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(entry_value)))
        else $error("stalled result beat changed or dropped");

endmodule

bind vector_clock_unit_core vcu_chk u_vcu_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .entry_value    (result.entry_value),
    .overflow       (result.overflow),
    .relation_valid (result.relation_valid),
    .relation       (result.relation)
);
